// ----- design/heartbeat_trace_plotter_defines.svh -----
// Assertion macros shared by the plotter modules.
`ifndef HEARTBEAT_TRACE_PLOTTER_DEFINES_SVH
`define HEARTBEAT_TRACE_PLOTTER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define HBTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define HBTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hbtp_pkg.sv -----
package hbtp_pkg;

    localparam int SAMPLE_BITS_DEF = 18;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int X_STEP_DEF      = 2;

    localparam int GAIN_W      = 8;
    localparam int MIN_RANGE_W = 18;
    localparam int COORD_W     = 9;
    localparam int OFFSET_W    = 8;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_INDEX_W = 3;

    localparam int TRACE_MARGIN = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RANGE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_LEFT        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_WRAP        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_CLIP_TOP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_CLIP_BOTTOM = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_CENTER      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRACE_OFFSET  = 3'd7;

    localparam logic [GAIN_W-1:0]      GAIN_RST          = 8'd50;
    localparam logic [MIN_RANGE_W-1:0] MIN_RANGE_RST     = 18'd500;
    localparam logic [COORD_W-1:0]     X_LEFT_RST        = 9'd6;
    localparam logic [COORD_W-1:0]     X_WRAP_RST        = 9'd233;
    localparam logic [COORD_W-1:0]     Y_CLIP_TOP_RST    = 9'd131;
    localparam logic [COORD_W-1:0]     Y_CLIP_BOTTOM_RST = 9'd199;
    localparam logic [COORD_W-1:0]     Y_CENTER_RST      = 9'd165;
    localparam logic [OFFSET_W-1:0]    TRACE_OFFSET_RST  = 8'd35;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/hbtp_div.sv -----
`include "heartbeat_trace_plotter_defines.svh"

module hbtp_div #(
    parameter int NUM_BITS = 34,
    parameter int DEN_BITS = 18
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_BITS-1:0]   dividend,
    input  logic [DEN_BITS-1:0]   divisor,
    output logic [NUM_BITS-1:0]   quotient,
    output hbtp_pkg::div_stat_t   stat
);
    import hbtp_pkg::*;

    localparam int CNT_W = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BITS - 1);

    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS:0]   rem_sub;
    logic                fits;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_BITS-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        fits    = rem_sh >= {1'b0, den_reg};

        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restore unless the shifted remainder covers the divisor
            num_next = num_reg << 1;
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            rem_next = fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `HBTP_ASSERT_NEXT(a_start_busy, start, busy_reg, "divider did not go busy on start")
    `HBTP_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "divider done while still busy")
    `HBTP_ASSERT_NEXT(a_last_done, busy_reg && !start && cnt_reg == CNT_LAST, done_reg,
        "divider missed done after final step")

endmodule

// ----- design/heartbeat_trace_plotter.sv -----
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     sample
// out       output     out_valid / out_ready   kind, x_from, y_from, x_to, y_to, last
// cfg       input      cfg_we (no wait)        cfg_index, cfg_data
//
// A drawing sample passes the span, multiply, divide start, divide wait, trace and row states;
// the divider covers SAMPLE_BITS + 8 + FRAC_BITS bits. The next transfer waits for its segment,
// and on a wrap the clear, to be taken. A first sample only seeds the span and emits nothing.
// in_ready is high only while idle; each result waits in the output register
// until its transfer, and a stalled out_ready holds the whole block.
// Reset loads the register defaults and clears the trace state at once.
`include "heartbeat_trace_plotter_defines.svh"

module heartbeat_trace_plotter #(
    parameter int SAMPLE_BITS = hbtp_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = hbtp_pkg::FRAC_BITS_DEF,
    parameter int X_STEP      = hbtp_pkg::X_STEP_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [hbtp_pkg::COORD_W-1:0]      x_from,
    output logic [hbtp_pkg::COORD_W-1:0]      y_from,
    output logic [hbtp_pkg::COORD_W-1:0]      x_to,
    output logic [hbtp_pkg::COORD_W-1:0]      y_to,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [hbtp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hbtp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hbtp_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int TW     = FRAC_BITS + 10;
    localparam int CW     = (NUM_W > TW) ? NUM_W + 1 : TW + 2;
    localparam int Y_W    = TW - FRAC_BITS + 1;
    localparam int SPAN_W = (SAMPLE_BITS > MIN_RANGE_W) ? SAMPLE_BITS : MIN_RANGE_W;
    localparam int LO_MAG = TRACE_MARGIN * (2 ** FRAC_BITS);
    localparam logic signed [CW-1:0] TRACE_LO = CW'(-LO_MAG);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_TRACE,
        S_ROW,
        S_SEG,
        S_CLR
    } state_t;

    function automatic logic [COORD_W-1:0] row_of(
        input logic signed [Y_W-1:0] y,
        input logic [COORD_W-1:0]    center,
        input logic [COORD_W-1:0]    top,
        input logic [COORD_W-1:0]    bot
    );
        logic signed [Y_W:0] r;
        r = $signed((Y_W+1)'(center)) - (Y_W+1)'(y);
        if (r < $signed((Y_W+1)'(top)))
            r = $signed((Y_W+1)'(top));
        if (r > $signed((Y_W+1)'(bot)))
            r = $signed((Y_W+1)'(bot));
        return r[COORD_W-1:0];
    endfunction

    logic [GAIN_W-1:0]      gain_reg;
    logic [MIN_RANGE_W-1:0] min_range_reg;
    logic [COORD_W-1:0]     x_left_reg;
    logic [COORD_W-1:0]     x_wrap_reg;
    logic [COORD_W-1:0]     y_top_reg;
    logic [COORD_W-1:0]     y_bot_reg;
    logic [COORD_W-1:0]     y_center_reg;
    logic [OFFSET_W-1:0]    offset_reg;

    state_t                  state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  span_min_reg, span_min_next;
    logic [SAMPLE_BITS-1:0]  span_max_reg, span_max_next;
    logic [SAMPLE_BITS-1:0]  prev_reg, prev_next;
    logic signed [TW-1:0]    trace_reg, trace_next;
    logic signed [Y_W-1:0]   last_y_reg, last_y_next;
    logic [COORD_W-1:0]      col_reg, col_next;
    logic [SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0]  span_reg, span_next;
    logic [SAMPLE_BITS-1:0]  delta_reg, delta_next;
    logic                    rise_reg, rise_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [NUM_W-1:0]        step_reg, step_next;
    logic                    wrap_reg, wrap_next;
    logic                    kind_reg, kind_next;
    logic [COORD_W-1:0]      x_from_reg, x_from_next;
    logic [COORD_W-1:0]      y_from_reg, y_from_next;
    logic [COORD_W-1:0]      x_to_reg, x_to_next;
    logic [COORD_W-1:0]      y_to_reg, y_to_next;
    logic                    last_reg, last_next;

    logic                    div_start;
    logic [NUM_W-1:0]        quotient;
    div_stat_t               div_stat;

    logic [SAMPLE_BITS-1:0]  acc_min;
    logic [SAMPLE_BITS-1:0]  acc_max;
    logic                    small_span;
    logic                    rise_now;
    logic signed [CW-1:0]    trace_w;
    logic signed [CW-1:0]    step_w;
    logic signed [CW-1:0]    hi_w;
    logic signed [CW-1:0]    headroom;
    logic signed [CW-1:0]    room;
    logic signed [CW-1:0]    trace_new;
    logic [TW-1:0]           trace_mag;
    logic [TW-FRAC_BITS-1:0] trace_int;
    logic signed [Y_W-1:0]   y_trunc;
    logic signed [Y_W-1:0]   y_new;
    logic [COORD_W:0]        col_step;
    logic                    wrap_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            min_range_reg <= MIN_RANGE_RST;
            x_left_reg    <= X_LEFT_RST;
            x_wrap_reg    <= X_WRAP_RST;
            y_top_reg     <= Y_CLIP_TOP_RST;
            y_bot_reg     <= Y_CLIP_BOTTOM_RST;
            y_center_reg  <= Y_CENTER_RST;
            offset_reg    <= TRACE_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN:          gain_reg      <= cfg_data[GAIN_W-1:0];
                CFG_MIN_RANGE:     min_range_reg <= cfg_data[MIN_RANGE_W-1:0];
                CFG_X_LEFT:        x_left_reg    <= cfg_data[COORD_W-1:0];
                CFG_X_WRAP:        x_wrap_reg    <= cfg_data[COORD_W-1:0];
                CFG_Y_CLIP_TOP:    y_top_reg     <= cfg_data[COORD_W-1:0];
                CFG_Y_CLIP_BOTTOM: y_bot_reg     <= cfg_data[COORD_W-1:0];
                CFG_Y_CENTER:      y_center_reg  <= cfg_data[COORD_W-1:0];
                CFG_TRACE_OFFSET:  offset_reg    <= cfg_data[OFFSET_W-1:0];
                default:           ;
            endcase
        end
    end

    hbtp_div #(
        .NUM_BITS (NUM_W),
        .DEN_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({prod_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (span_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign div_start = (state_reg == S_DIV_START);

    always_comb
    begin
        acc_min    = (sample < span_min_reg) ? sample : span_min_reg;
        acc_max    = (sample > span_max_reg) ? sample : span_max_reg;
        small_span = SPAN_W'(span_max_reg - span_min_reg) < SPAN_W'(min_range_reg);
        rise_now   = sample_reg > prev_reg;

        trace_w  = CW'(trace_reg);
        step_w   = $signed(CW'(step_reg));
        hi_w     = $signed((CW'(gain_reg) + CW'(TRACE_MARGIN)) << FRAC_BITS);
        headroom = trace_w - TRACE_LO;
        room     = hi_w - trace_w;
        if (rise_reg)
            trace_new = (step_w > headroom) ? TRACE_LO : trace_w - step_w;
        else if (room < 0 || step_w > room)
            trace_new = hi_w;
        else
            trace_new = trace_w + step_w;

        // truncate toward zero
        trace_mag = (trace_reg < 0) ? TW'(-trace_reg) : TW'(trace_reg);
        trace_int = trace_mag[TW-1:FRAC_BITS];
        y_trunc   = (trace_reg < 0) ? -$signed({1'b0, trace_int}) : $signed({1'b0, trace_int});
        y_new     = y_trunc + $signed(Y_W'(offset_reg));

        col_step = {1'b0, col_reg} + (COORD_W+1)'(X_STEP);
        wrap_now = col_step >= {1'b0, x_wrap_reg};
    end

    always_comb
    begin
        state_next    = state_reg;
        span_min_next = span_min_reg;
        span_max_next = span_max_reg;
        prev_next     = prev_reg;
        trace_next    = trace_reg;
        last_y_next   = last_y_reg;
        col_next      = col_reg;
        sample_next   = sample_reg;
        span_next     = span_reg;
        delta_next    = delta_reg;
        rise_next     = rise_reg;
        prod_next     = prod_reg;
        step_next     = step_reg;
        wrap_next     = wrap_reg;
        kind_next     = kind_reg;
        x_from_next   = x_from_reg;
        y_from_next   = y_from_reg;
        x_to_next     = x_to_reg;
        y_to_next     = y_to_reg;
        last_next     = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    if (prev_reg == '0)
                    begin
                        prev_next     = sample;
                        span_min_next = sample;
                        span_max_next = sample;
                    end
                    else
                    begin
                        span_min_next = acc_min;
                        span_max_next = acc_max;
                        state_next    = S_SPAN;
                    end
                end
            end
            S_SPAN:
            begin
                span_next  = span_max_reg - span_min_reg;
                rise_next  = rise_now;
                delta_next = rise_now ? sample_reg - prev_reg : prev_reg - sample_reg;
                state_next = small_span ? S_IDLE : S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(delta_reg) * PROD_W'(gain_reg);
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    step_next  = (delta_reg == '0) ? '0 : quotient;
                    state_next = S_TRACE;
                end
            end
            S_TRACE:
            begin
                trace_next = trace_new[TW-1:0];
                state_next = S_ROW;
            end
            S_ROW:
            begin
                kind_next   = KIND_SEGMENT;
                x_from_next = col_reg;
                y_from_next = row_of(last_y_reg, y_center_reg, y_top_reg, y_bot_reg);
                x_to_next   = col_step[COORD_W-1:0];
                y_to_next   = row_of(y_new, y_center_reg, y_top_reg, y_bot_reg);
                last_next   = !wrap_now;
                wrap_next   = wrap_now;
                last_y_next = y_new;
                prev_next   = sample_reg;
                if (wrap_now)
                begin
                    col_next      = x_left_reg;
                    span_min_next = '1;
                    span_max_next = '0;
                end
                else
                begin
                    col_next = col_step[COORD_W-1:0];
                end
                state_next = S_SEG;
            end
            S_SEG:
            begin
                if (out_ready)
                begin
                    if (wrap_reg)
                    begin
                        kind_next   = KIND_CLEAR;
                        x_from_next = x_left_reg;
                        y_from_next = y_top_reg;
                        x_to_next   = x_wrap_reg + 1'b1;
                        y_to_next   = y_bot_reg;
                        last_next   = 1'b1;
                        state_next  = S_CLR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLR:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            span_min_reg <= '1;
            span_max_reg <= '0;
            prev_reg     <= '0;
            trace_reg    <= '0;
            last_y_reg   <= Y_W'(TRACE_OFFSET_RST);
            col_reg      <= X_LEFT_RST;
            sample_reg   <= '0;
            span_reg     <= '0;
            delta_reg    <= '0;
            rise_reg     <= 1'b0;
            prod_reg     <= '0;
            step_reg     <= '0;
            wrap_reg     <= 1'b0;
            kind_reg     <= KIND_SEGMENT;
            x_from_reg   <= '0;
            y_from_reg   <= '0;
            x_to_reg     <= '0;
            y_to_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            span_min_reg <= span_min_next;
            span_max_reg <= span_max_next;
            prev_reg     <= prev_next;
            trace_reg    <= trace_next;
            last_y_reg   <= last_y_next;
            col_reg      <= col_next;
            sample_reg   <= sample_next;
            span_reg     <= span_next;
            delta_reg    <= delta_next;
            rise_reg     <= rise_next;
            prod_reg     <= prod_next;
            step_reg     <= step_next;
            wrap_reg     <= wrap_next;
            kind_reg     <= kind_next;
            x_from_reg   <= x_from_next;
            y_from_reg   <= y_from_next;
            x_to_reg     <= x_to_next;
            y_to_reg     <= y_to_next;
            last_reg     <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SEG) || (state_reg == S_CLR);
    assign kind      = kind_reg;
    assign x_from    = x_from_reg;
    assign y_from    = y_from_reg;
    assign x_to      = x_to_reg;
    assign y_to      = y_to_reg;
    assign last      = last_reg;

    `HBTP_ASSERT_NOW(a_out_blocks_in, out_valid, !in_ready, "input taken while a result waits")
    `HBTP_ASSERT_NOW(a_clear_is_last, out_valid && kind == KIND_CLEAR, last,
        "clear command not marked last")
    `HBTP_ASSERT_NEXT(a_accept_no_out, in_valid && in_ready, !out_valid,
        "result shown right after an input transfer")
    `HBTP_ASSERT_NOW(a_div_done_wait, div_stat.done, state_reg == S_DIV_WAIT,
        "divider finished outside its wait state")

endmodule

// ----- dv/heartbeat_trace_plotter_tb.sv -----
module heartbeat_trace_plotter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbtp_pkg::*;

    localparam int     SAMPLE_W       = SAMPLE_BITS_DEF;
    localparam longint FRAC_SCALE     = longint'(1) << FRAC_BITS_DEF;
    localparam int     LATENCY_CYCLES = 64;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x_from;
        logic [COORD_W-1:0] y_from;
        logic [COORD_W-1:0] x_to;
        logic [COORD_W-1:0] y_to;
        logic               last;
    } plot_cmd_t;

    class trace_scoreboard;
        logic [GAIN_W-1:0]      gain;
        logic [MIN_RANGE_W-1:0] min_range;
        logic [COORD_W-1:0]     x_left;
        logic [COORD_W-1:0]     x_wrap;
        logic [COORD_W-1:0]     clip_top;
        logic [COORD_W-1:0]     clip_bottom;
        logic [COORD_W-1:0]     center;
        logic [OFFSET_W-1:0]    offset;

        logic [SAMPLE_W-1:0]    span_lo;
        logic [SAMPLE_W-1:0]    span_hi;
        logic [SAMPLE_W-1:0]    prev_sample;
        longint                 trace_q8;
        int                     trace_y_last;
        logic [COORD_W-1:0]     column;

        plot_cmd_t              due[$];
        int                     errors;
        int                     samples;
        int                     segments;
        int                     clears;

        function new();
            gain         = GAIN_RST;
            min_range    = MIN_RANGE_RST;
            x_left       = X_LEFT_RST;
            x_wrap       = X_WRAP_RST;
            clip_top     = Y_CLIP_TOP_RST;
            clip_bottom  = Y_CLIP_BOTTOM_RST;
            center       = Y_CENTER_RST;
            offset       = TRACE_OFFSET_RST;
            span_lo      = '1;
            span_hi      = '0;
            prev_sample  = '0;
            trace_q8     = 0;
            trace_y_last = int'(TRACE_OFFSET_RST);
            column       = X_LEFT_RST;
        endfunction

        function void configure(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_GAIN:          gain        = val[GAIN_W-1:0];
                CFG_MIN_RANGE:     min_range   = val[MIN_RANGE_W-1:0];
                CFG_X_LEFT:        x_left      = val[COORD_W-1:0];
                CFG_X_WRAP:        x_wrap      = val[COORD_W-1:0];
                CFG_Y_CLIP_TOP:    clip_top    = val[COORD_W-1:0];
                CFG_Y_CLIP_BOTTOM: clip_bottom = val[COORD_W-1:0];
                CFG_Y_CENTER:      center      = val[COORD_W-1:0];
                CFG_TRACE_OFFSET:  offset      = val[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function int screen_row(int y);
            int r;
            r = int'(center) - y;
            if (r < int'(clip_top))
                r = int'(clip_top);
            if (r > int'(clip_bottom))
                r = int'(clip_bottom);
            return r;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            logic [SAMPLE_W-1:0] span;
            logic [SAMPLE_W-1:0] delta;
            logic                rising;
            longint              d;
            longint              sp;
            longint              step;
            longint              lo_lim;
            longint              hi_lim;
            int                  y;
            int                  row_old;
            int                  row_new;
            int                  nxt;
            plot_cmd_t           cmd;
            samples++;
            if (prev_sample == '0)
            begin
                prev_sample = s;
                span_lo     = s;
                span_hi     = s;
                return;
            end
            if (s < span_lo)
                span_lo = s;
            if (s > span_hi)
                span_hi = s;
            span = span_hi - span_lo;
            if (span < min_range)
                return;

            rising = s > prev_sample;
            delta  = rising ? s - prev_sample : prev_sample - s;
            d      = longint'(delta);
            sp     = longint'(span);
            if (sp == 0)
                step = (d == 0) ? 0 : (longint'(1) <<< 50);
            else
                step = (d * longint'(gain) * FRAC_SCALE) / sp;

            lo_lim = -(longint'(TRACE_MARGIN) * FRAC_SCALE);
            hi_lim = (longint'(gain) + TRACE_MARGIN) * FRAC_SCALE;
            if (rising)
            begin
                trace_q8 -= step;
                if (trace_q8 < lo_lim)
                    trace_q8 = lo_lim;
            end
            else
            begin
                trace_q8 += step;
                if (trace_q8 > hi_lim)
                    trace_q8 = hi_lim;
            end

            // signed division truncates toward zero
            y = int'(trace_q8 / FRAC_SCALE) + int'(offset);

            row_old      = screen_row(trace_y_last);
            row_new      = screen_row(y);
            trace_y_last = y;
            prev_sample  = s;
            nxt          = int'(column) + X_STEP_DEF;

            cmd.kind   = KIND_SEGMENT;
            cmd.x_from = column;
            cmd.y_from = row_old[COORD_W-1:0];
            cmd.x_to   = nxt[COORD_W-1:0];
            cmd.y_to   = row_new[COORD_W-1:0];
            cmd.last   = 1'b1;

            if (nxt >= int'(x_wrap))
            begin
                cmd.last = 1'b0;
                due.push_back(cmd);
                cmd.kind   = KIND_CLEAR;
                cmd.x_from = x_left;
                cmd.y_from = clip_top;
                cmd.x_to   = x_wrap + 1'b1;
                cmd.y_to   = clip_bottom;
                cmd.last   = 1'b1;
                due.push_back(cmd);
                column  = x_left;
                span_lo = '1;
                span_hi = '0;
            end
            else
            begin
                due.push_back(cmd);
                column = nxt[COORD_W-1:0];
            end
        endfunction

        function void check_result(plot_cmd_t got);
            plot_cmd_t want;
            string     names[6];
            int        want_f[6];
            int        got_f[6];
            if (due.size() == 0)
            begin
                $error("unexpected result: kind %0d x_from %0d y_from %0d x_to %0d y_to %0d",
                       got.kind, got.x_from, got.y_from, got.x_to, got.y_to);
                errors++;
                return;
            end
            want   = due.pop_front();
            names  = '{"kind", "x_from", "y_from", "x_to", "y_to", "last"};
            want_f = '{want.kind, want.x_from, want.y_from, want.x_to, want.y_to, want.last};
            got_f  = '{got.kind, got.x_from, got.y_from, got.x_to, got.y_to, got.last};
            for (int i = 0; i < 6; i++)
            begin
                if (want_f[i] != got_f[i])
                begin
                    $error("%s: expected %0d, got %0d", names[i], want_f[i], got_f[i]);
                    errors++;
                end
            end
            if (got.kind == KIND_CLEAR)
                clears++;
            else
                segments++;
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample;
    logic                   out_valid;
    logic                   out_ready;
    logic                   kind;
    logic [COORD_W-1:0]     x_from;
    logic [COORD_W-1:0]     y_from;
    logic [COORD_W-1:0]     x_to;
    logic [COORD_W-1:0]     y_to;
    logic                   last;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    trace_scoreboard        sb = new();
    int                     quiet_cycles;
    int                     settings_run;
    bit                     steady_in;
    bit                     squeeze_req;

    int                     wave_base;
    int                     wave_amp;
    int                     wave_period;
    int                     wave_noise;
    int                     wave_tick;
    logic [SAMPLE_W-1:0]    last_value;

    logic [SAMPLE_W-1:0]    opening [22] = '{
        18'd0, 18'd0, 18'd262143, 18'd262143, 18'd1, 18'd1, 18'd262143, 18'd262143,
        18'd0, 18'd200, 18'd900, 18'd600, 18'd700, 18'd650, 18'd131072, 18'd131073,
        18'd131071, 18'h15555, 18'h2AAAA, 18'd3, 18'd262142, 18'd65535
    };

    heartbeat_trace_plotter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .x_from    (x_from),
        .y_from    (y_from),
        .x_to      (x_to),
        .y_to      (y_to),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_sample(sample);
            if (out_valid && out_ready)
                sb.check_result(plot_cmd_t'{kind, x_from, y_from, x_to, y_to, last});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d results outstanding",
                       quiet_cycles, sb.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: ready runs broken by stalls, one long hold-off on request
    initial
    begin
        int stall;
        int r;
        out_ready <= 1'b0;
        @(posedge clk);
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            r = $urandom_range(0, 99);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (r < 30)
                stall = 0;
            else if (r < 70)
                stall = $urandom_range(1, 2);
            else if (r < 94)
                stall = $urandom_range(3, 8);
            else
                stall = $urandom_range(20, 60);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    function automatic void new_waveform();
        wave_base   = $urandom_range(1000, 200000);
        wave_amp    = $urandom_range(300, 40000);
        wave_period = $urandom_range(8, 40);
        wave_noise  = $urandom_range(0, 400);
        wave_tick   = 0;
    endfunction

    // mostly a pulse-like wave around a baseline, the rest noise and extremes
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int r;
        int pos;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 4))
                0:       v = 0;
                1:       v = 1;
                2:       v = SAMPLE_MAX;
                3:       v = SAMPLE_MAX - 1;
                default: v = last_value;
            endcase
        end
        else if (r < 22)
            v = $urandom_range(0, SAMPLE_MAX);
        else
        begin
            wave_tick++;
            if (wave_tick >= wave_period)
            begin
                wave_tick = 0;
                if ($urandom_range(0, 9) == 0)
                    new_waveform();
            end
            pos = (2 * wave_tick < wave_period) ? wave_tick : wave_period - wave_tick;
            v = wave_base + (wave_amp * pos * 2) / wave_period + $urandom_range(0, wave_noise);
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            if (v < 1)
                v = 1;
        end
        last_value = v[SAMPLE_W-1:0];
        return last_value;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (steady_in || r < 55)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid, wait out every expected result, then the block's own latency
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.configure(idx, val);
    endtask

    task automatic write_setup(input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] mr,
                               input logic [CFG_DATA_W-1:0] xl, input logic [CFG_DATA_W-1:0] xw,
                               input logic [CFG_DATA_W-1:0] ct, input logic [CFG_DATA_W-1:0] cb,
                               input logic [CFG_DATA_W-1:0] yc, input logic [CFG_DATA_W-1:0] off);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_MIN_RANGE, mr);
        write_reg(CFG_X_LEFT, xl);
        write_reg(CFG_X_WRAP, xw);
        write_reg(CFG_Y_CLIP_TOP, ct);
        write_reg(CFG_Y_CLIP_BOTTOM, cb);
        write_reg(CFG_Y_CENTER, yc);
        write_reg(CFG_TRACE_OFFSET, off);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic run_phase(input int count, input bit hurry);
        new_waveform();
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                steady_in = (hurry && n < 80) || ($urandom_range(0, 3) == 0);
            send_sample(next_sample());
        end
        settle();
    endtask

    initial
    begin
        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_GAIN;
        cfg_data  <= '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        steady_in = 1'b0;
        foreach (opening[i])
            send_sample(opening[i]);
        settle();
        settings_run = 1;

        write_setup(18'd255, 18'd0, 18'd200, 18'd319, 18'd0, 18'd319, 18'd511, 18'd255);
        run_phase(110, 1'b0);

        // inverted clip window, huge span floor, every draw wraps
        write_setup(18'd1, 18'd262143, 18'd300, 18'd40, 18'd319, 18'd0, 18'd0, 18'd0);
        run_phase(60, 1'b0);

        // hold off the receiver while the sender keeps offering
        write_setup(18'd128, 18'd1000, 18'd10, 18'd60, 18'd100, 18'd220, 18'd180, 18'd40);
        squeeze_req = 1'b1;
        run_phase(150, 1'b1);

        // upper data bits set, wrap column zero, left column at the top of the field
        write_setup(18'h3FF09, 18'd0, 18'h3FFFF, 18'd0, 18'd400, 18'd511, 18'd300, 18'h3FFC8);
        run_phase(80, 1'b0);

        write_setup(18'd90, 18'd50, 18'd511, 18'd511, 18'd120, 18'd200, 18'd160, 18'd30);
        run_phase(80, 1'b0);

        write_setup(CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(MIN_RANGE_RST), CFG_DATA_W'(X_LEFT_RST),
                    CFG_DATA_W'(X_WRAP_RST), CFG_DATA_W'(Y_CLIP_TOP_RST),
                    CFG_DATA_W'(Y_CLIP_BOTTOM_RST), CFG_DATA_W'(Y_CENTER_RST),
                    CFG_DATA_W'(TRACE_OFFSET_RST));
        run_phase(100, 1'b0);

        repeat (3)
        begin
            write_setup(CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)),
                        CFG_DATA_W'($urandom_range(0, 2000)),
                        CFG_DATA_W'($urandom_range(0, 319)),
                        CFG_DATA_W'($urandom_range(0, 319)),
                        CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)),
                        CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)),
                        CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)),
                        CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)));
            run_phase(100, 1'b0);
        end

        $display("Covered %0d samples under %0d register settings: %0d segments, %0d clears",
                 sb.samples, settings_run, sb.segments, sb.clears);
        $display("Mismatches and unexpected results: %0d", sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
